### hw/rtl/pst_pkg.sv
// Package: shared types, constants and opcodes of the point-set transform block.
`timescale 1ns / 1ps
package pst_pkg;
	localparam int MAX_POINTS_DEF = 64;
	localparam int CW = 32;
	localparam int SW = 38;

	localparam logic [3:0] OP_ROT_X  = 4'd0;
	localparam logic [3:0] OP_ROT_Y  = 4'd1;
	localparam logic [3:0] OP_ROT_Z  = 4'd2;
	localparam logic [3:0] OP_UP     = 4'd3;
	localparam logic [3:0] OP_DOWN   = 4'd4;
	localparam logic [3:0] OP_LEFT   = 4'd5;
	localparam logic [3:0] OP_RIGHT  = 4'd6;
	localparam logic [3:0] OP_MDOWN  = 4'd7;
	localparam logic [3:0] OP_MUP    = 4'd8;

	localparam logic [2:0] REG_OP     = 3'd0;
	localparam logic [2:0] REG_USEC   = 3'd1;
	localparam logic [2:0] REG_CX     = 3'd2;
	localparam logic [2:0] REG_CY     = 3'd3;
	localparam logic [2:0] REG_CZ     = 3'd4;
	localparam logic [2:0] REG_ROT    = 3'd5;
	localparam logic [2:0] REG_SCALE  = 3'd6;
	localparam logic [2:0] REG_STEP   = 3'd7;

	typedef enum logic [2:0] {
		ST_LOAD, ST_DIV, ST_RD, ST_CALC, ST_OUT
	} state_t;

	typedef struct packed {
		logic store;     // store and sum incoming point
		logic div_start; // start centroid division
		logic rd;        // read store entry
		logic calc;      // advance arithmetic pipeline
		logic out_load;  // load output register
		logic clear;     // end of batch
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic calc_done;
		logic last_rd;
		logic full;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

### hw/rtl/point_set_transform_about_center_top.sv
// Top level of the point-set transform block.
`timescale 1ns / 1ps
// Usage:
//  s_axis carries points; tlast marks the final point of a batch (at most
//  MAX_POINTS points are kept, extra ones dropped, their tlast still ends it).
//  Points are accepted whenever the block is loading.
//  After the last point the centroid is formed by a shift-subtract
//  divider; with the configured centre the divider is skipped.
//  Each stored point then passes through store read, multiply, sum/round
//  and output register, and leaves on m_axis, tlast on the final one.
//  s_axis_tready is low while a batch is being emitted.
//  A stalled receiver holds the output register; the next point waits.
//  cfg channel writes register cfg_index with cfg_data; always ready.
//  Reset clears the batch, sums and registers to their defaults; store
//  contents are not cleared and need no clearing pass.
module point_set_transform_about_center_top import pst_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [95:0] s_axis_tdata, // point_x, point_y, point_z
	input  logic s_axis_tlast,        // batch_end
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [95:0] m_axis_tdata, // out_x, out_y, out_z
	output logic m_axis_tlast,        // out_last
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [63:0] cfg_data
);
	logic [3:0] op_q;
	logic use_q;
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [63:0] rot_q, scl_q;
	logic [30:0] step_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= 4'd10; use_q <= 1'b0;
			cx_q <= '0; cy_q <= '0; cz_q <= '0;
			rot_q <= 64'd1073741824;
			scl_q <= 64'd72057594054705152;
			step_q <= 31'd65536;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_OP:    op_q <= cfg_data[3:0];
				REG_USEC:  use_q <= cfg_data[0];
				REG_CX:    cx_q <= cfg_data[31:0];
				REG_CY:    cy_q <= cfg_data[31:0];
				REG_CZ:    cz_q <= cfg_data[31:0];
				REG_ROT:   rot_q <= cfg_data;
				REG_SCALE: scl_q <= cfg_data;
				REG_STEP:  step_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	cmd_t cmd;
	sts_t sts;
	logic in_fire, out_fire, out_busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = out_busy;

	pst_ctrl u_ctrl (.clk, .arst_n, .in_fire, .in_last(s_axis_tlast), .out_busy,
		.out_fire, .sts, .cmd, .in_rdy(s_axis_tready));

	pst_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (.clk, .arst_n, .cmd, .sts,
		.in_pt(s_axis_tdata), .op(op_q), .use_c(use_q), .cfg_cx(cx_q),
		.cfg_cy(cy_q), .cfg_cz(cz_q), .rot(rot_q), .scl(scl_q), .step(step_q),
		.out_fire, .out_busy, .out_pt(m_axis_tdata), .out_lst(m_axis_tlast));
endmodule

### hw/rtl/pst_ctrl.sv
// Controller state machine of the point-set transform block.
`timescale 1ns / 1ps
module pst_ctrl import pst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic in_last,
	input  logic out_busy,
	input  logic out_fire,
	input  sts_t sts,
	output cmd_t cmd,
	output logic in_rdy
);
	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_LOAD: if (in_fire && in_last) state_n = ST_DIV;
			ST_DIV:  if (sts.div_done) state_n = ST_RD;
			ST_RD:   state_n = ST_CALC;
			ST_CALC: if (sts.calc_done) state_n = ST_OUT;
			ST_OUT:  if (!out_busy || out_fire)
				state_n = sts.last_rd ? ST_LOAD : ST_RD;
			default: state_n = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_rdy = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_rdy = 1'b1;
				cmd.store = in_fire;
				cmd.div_start = in_fire && in_last;
			end
			ST_RD:   cmd.rd = 1'b1;
			ST_CALC: cmd.calc = 1'b1;
			ST_OUT: if (!out_busy || out_fire) begin
				cmd.out_load = 1'b1;
				cmd.clear = sts.last_rd;
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_rdy |-> state_q == ST_LOAD) else $error("ready outside load");
	a_clear_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> cmd.out_load) else $error("clear without output");
	a_rd_calc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |=> state_q == ST_CALC) else $error("read not followed by calc");
`endif
endmodule

### hw/rtl/pst_div.sv
// Sequential signed divider for the centroid (restoring, one bit a cycle).
`timescale 1ns / 1ps
module pst_div import pst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [SW-1:0] num,
	input  logic [6:0] den,
	output logic done,
	output logic signed [CW-1:0] quo
);
	logic [SW-1:0] a_q, q_q;
	logic [6:0] r_q;
	logic neg_q, busy_q;
	logic [5:0] cnt_q;
	logic [7:0] trial;

	assign trial = {r_q, a_q[SW-1]} - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(SW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= num[SW-1] ? SW'(-num) : num;
			neg_q <= num[SW-1];
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[SW-2:0], 1'b0};
			if (!trial[7]) begin
				r_q <= trial[6:0];
				q_q <= {q_q[SW-2:0], 1'b1};
			end else begin
				r_q <= {r_q[5:0], a_q[SW-1]};
				q_q <= {q_q[SW-2:0], 1'b0};
			end
		end
	end

	logic [SW-1:0] qs;
	assign qs = neg_q ? SW'(-q_q) : q_q;
	assign quo = qs[CW-1:0];
endmodule

### hw/rtl/pst_dp.sv
// Datapath: point store, sums, centroid, transform arithmetic and output register.
`timescale 1ns / 1ps
module pst_dp import pst_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output sts_t sts,
	input  logic [95:0] in_pt,
	input  logic [3:0] op,
	input  logic use_c,
	input  logic signed [31:0] cfg_cx, cfg_cy, cfg_cz,
	input  logic [63:0] rot,
	input  logic [63:0] scl,
	input  logic [30:0] step,
	input  logic out_fire,
	output logic out_busy,
	output logic [95:0] out_pt,
	output logic out_lst
);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int NW = $clog2(MAX_POINTS + 1);

	logic [95:0] mem [MAX_POINTS];
	logic [NW-1:0] cnt_q, rd_q;
	logic signed [SW-1:0] sx_q, sy_q, sz_q;
	logic [95:0] rd_s1;
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [1:0] dph_q;
	logic signed [31:0] qx, qy, qz;
	logic ddx, ddy, ddz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; rd_q <= '0;
			sx_q <= '0; sy_q <= '0; sz_q <= '0;
		end else begin
			if (cmd.store && !sts.full) begin
				cnt_q <= cnt_q + 1'b1;
				sx_q <= sx_q + SW'($signed(in_pt[31:0]));
				sy_q <= sy_q + SW'($signed(in_pt[63:32]));
				sz_q <= sz_q + SW'($signed(in_pt[95:64]));
			end
			if (cmd.rd) rd_q <= rd_q + 1'b1;
			if (cmd.clear) begin
				cnt_q <= '0; rd_q <= '0;
				sx_q <= '0; sy_q <= '0; sz_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store && !sts.full) mem[cnt_q[AW-1:0]] <= in_pt;
		if (cmd.rd) rd_s1 <= mem[rd_q[AW-1:0]];
	end

	logic [6:0] den;
	assign den = 7'(cnt_q + NW'(cmd.store && !sts.full));

	// divider starts with the sums after the final point is folded in
	logic dgo_q;
	logic skip_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dgo_q <= 1'b0; skip_q <= 1'b0;
		end else begin
			dgo_q <= cmd.div_start && !use_c && den != 0;
			skip_q <= cmd.div_start && (use_c || den == 0);
		end
	end

	pst_div u_dx (.clk, .arst_n, .start(dgo_q), .num(sx_q), .den(7'(cnt_q)), .done(ddx), .quo(qx));
	pst_div u_dy (.clk, .arst_n, .start(dgo_q), .num(sy_q), .den(7'(cnt_q)), .done(ddy), .quo(qy));
	pst_div u_dz (.clk, .arst_n, .start(dgo_q), .num(sz_q), .den(7'(cnt_q)), .done(ddz), .quo(qz));

	logic ddall;
	assign ddall = ddx && ddy && ddz;

	always_ff @(posedge clk) begin
		if (skip_q) begin
			cx_q <= cfg_cx; cy_q <= cfg_cy; cz_q <= cfg_cz;
		end else if (ddall) begin
			cx_q <= qx; cy_q <= qy; cz_q <= qz;
		end
	end

	// arithmetic: phase 0 products, phase 1 sums and rounding
	logic signed [31:0] px, py, pz, cs, sn;
	logic signed [32:0] dx, dy, dz, fk;
	assign px = rd_s1[31:0];
	assign py = rd_s1[63:32];
	assign pz = rd_s1[95:64];
	assign cs = rot[31:0];
	assign sn = rot[63:32];
	assign fk = (op == OP_UP) ? {1'b0, scl[31:0]} : {1'b0, scl[63:32]};
	assign dx = 33'(px) - 33'(cx_q);
	assign dy = 33'(py) - 33'(cy_q);
	assign dz = 33'(pz) - 33'(cz_q);

	logic signed [32:0] a1, a2, b1, b2;
	logic signed [32:0] k1, k2, k3, k4;
	always_comb begin
		a1 = dy; k1 = 33'(cs); a2 = dz; k2 = -33'(sn);
		b1 = dy; k3 = 33'(sn); b2 = dz; k4 = 33'(cs);
		case (op)
			OP_ROT_Y: begin
				a1 = dx; k1 = 33'(cs); a2 = dz; k2 = 33'(sn);
				b1 = dx; k3 = -33'(sn); b2 = dz; k4 = 33'(cs);
			end
			OP_ROT_Z: begin
				a1 = dx; k1 = 33'(cs); a2 = dy; k2 = -33'(sn);
				b1 = dx; k3 = 33'(sn); b2 = dy; k4 = 33'(cs);
			end
			OP_UP, OP_DOWN: begin
				a1 = dx; k1 = fk; a2 = dy; k2 = fk;
				b1 = dz; k3 = fk; b2 = '0; k4 = '0;
			end
			default: ;
		endcase
	end

	logic signed [65:0] m1_s1, m2_s1, m3_s1, m4_s1;
	always_ff @(posedge clk) begin
		if (cmd.calc && dph_q == 2'd0) begin
			m1_s1 <= 66'(a1) * 66'(k1);
			m2_s1 <= 66'(a2) * 66'(k2);
			m3_s1 <= 66'(b1) * 66'(k3);
			m4_s1 <= 66'(b2) * 66'(k4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dph_q <= '0;
		else if (cmd.calc) dph_q <= (dph_q == 2'd1) ? 2'd0 : dph_q + 2'd1;
	end

	assign sts = '{div_done: ddall || skip_q,
		calc_done: cmd.calc && dph_q == 2'd1,
		last_rd: (rd_q == cnt_q),
		full: (cnt_q == NW'(MAX_POINTS))};

	logic signed [66:0] r1, r2, rs1, rs2, rs3;
	assign r1 = (67'(m1_s1) + 67'(m2_s1) + 67'sd536870912) >>> 30;
	assign r2 = (67'(m3_s1) + 67'(m4_s1) + 67'sd536870912) >>> 30;
	assign rs1 = (67'(m1_s1) + 67'sd8388608) >>> 24;
	assign rs2 = (67'(m2_s1) + 67'sd8388608) >>> 24;
	assign rs3 = (67'(m3_s1) + 67'sd8388608) >>> 24;

	logic signed [65:0] nx, ny, nz;
	always_comb begin
		nx = 66'(px); ny = 66'(py); nz = 66'(pz);
		case (op)
			OP_ROT_X: begin ny = 66'(cy_q) + 66'(r1); nz = 66'(cz_q) + 66'(r2); end
			OP_ROT_Y: begin nx = 66'(cx_q) + 66'(r1); nz = 66'(cz_q) + 66'(r2); end
			OP_ROT_Z: begin nx = 66'(cx_q) + 66'(r1); ny = 66'(cy_q) + 66'(r2); end
			OP_UP, OP_DOWN: begin
				nx = 66'(cx_q) + 66'(rs1);
				ny = 66'(cy_q) + 66'(rs2);
				nz = 66'(cz_q) + 66'(rs3);
			end
			OP_LEFT:  nx = 66'(px) - 66'($signed({1'b0, step}));
			OP_RIGHT: nx = 66'(px) + 66'($signed({1'b0, step}));
			OP_MDOWN: ny = 66'(py) - 66'($signed({1'b0, step}));
			OP_MUP:   ny = 66'(py) + 66'($signed({1'b0, step}));
			default: ;
		endcase
	end

	logic [95:0] res_q;
	always_ff @(posedge clk) begin
		if (sts.calc_done) res_q <= {sat32(nz), sat32(ny), sat32(nx)};
		if (cmd.out_load) begin
			out_pt <= res_q;
			out_lst <= sts.last_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_busy <= 1'b0;
		else if (cmd.out_load) out_busy <= 1'b1;
		else if (out_fire) out_busy <= 1'b0;
	end

`ifndef SYNTH
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(MAX_POINTS)) else $error("count beyond depth");
	a_rd_le: assert property (@(posedge clk) disable iff (!arst_n)
		rd_q <= cnt_q) else $error("read beyond fill");
	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> cnt_q == 0) else $error("count not cleared");
`endif
endmodule

### bench/tb_top.sv
// Testbench for the point-set transform: random batches, self-predicted, checked per transfer.
`timescale 1ns / 1ps
module tb_top;
	import pst_pkg::*;

	typedef struct packed {
		logic [31:0] z;
		logic [31:0] y;
		logic [31:0] x;
		logic        last;
	} point_t;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready, s_axis_tlast;
	logic [95:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready, m_axis_tlast;
	logic [95:0] m_axis_tdata;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;

	point_t pending_points[$];
	point_t transformed_points[$];
	logic [31:0] batch_x[64], batch_y[64], batch_z[64];
	longint acc_x = 0, acc_y = 0, acc_z = 0;
	int unsigned batch_len = 0;

	logic [3:0]  op_reg;
	logic        given_centre;
	logic [31:0] centre_x, centre_y, centre_z;
	logic [63:0] cos_sin, scale_pair;
	logic [30:0] step_reg;

	int send_idle, recv_idle;
	int errors = 0, quiet_cycles = 0;

	point_transform_about_center_top_stub_guard u_unused ();

	point_set_transform_about_center_top DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// round half up of (d1*k1 + d2*k2) / 2^sh
	function automatic longint rot_sum(longint d1, longint k1, longint d2, longint k2, int sh);
		logic signed [95:0] a;
		a = 96'(signed'(d1)) * 96'(signed'(k1)) + 96'(signed'(d2)) * 96'(signed'(k2));
		a = (a + (96'sd1 <<< (sh - 1))) >>> sh;
		return longint'(a[63:0]);
	endfunction

	task automatic transform_batch();
		longint cx, cy, cz, c, s, f, x, y, z, nx, ny, nz;
		point_t r;
		if (given_centre || batch_len == 0) begin
			cx = longint'(signed'(centre_x));
			cy = longint'(signed'(centre_y));
			cz = longint'(signed'(centre_z));
		end else begin
			cx = acc_x / longint'(batch_len);
			cy = acc_y / longint'(batch_len);
			cz = acc_z / longint'(batch_len);
		end
		c = longint'(signed'(cos_sin[31:0]));
		s = longint'(signed'(cos_sin[63:32]));
		f = (op_reg == OP_UP) ? longint'(scale_pair[31:0]) : longint'(scale_pair[63:32]);
		for (int i = 0; i < batch_len; i++) begin
			x = longint'(signed'(batch_x[i]));
			y = longint'(signed'(batch_y[i]));
			z = longint'(signed'(batch_z[i]));
			nx = x; ny = y; nz = z;
			case (op_reg)
				OP_ROT_X: begin
					ny = cy + rot_sum(y - cy, c, z - cz, -s, 30);
					nz = cz + rot_sum(y - cy, s, z - cz, c, 30);
				end
				OP_ROT_Y: begin
					nx = cx + rot_sum(x - cx, c, z - cz, s, 30);
					nz = cz + rot_sum(x - cx, -s, z - cz, c, 30);
				end
				OP_ROT_Z: begin
					nx = cx + rot_sum(x - cx, c, y - cy, -s, 30);
					ny = cy + rot_sum(x - cx, s, y - cy, c, 30);
				end
				OP_UP, OP_DOWN: begin
					nx = cx + rot_sum(x - cx, f, 0, 0, 24);
					ny = cy + rot_sum(y - cy, f, 0, 0, 24);
					nz = cz + rot_sum(z - cz, f, 0, 0, 24);
				end
				OP_LEFT:  nx = x - longint'(step_reg);
				OP_RIGHT: nx = x + longint'(step_reg);
				OP_MDOWN: ny = y - longint'(step_reg);
				OP_MUP:   ny = y + longint'(step_reg);
				default: ;
			endcase
			r.x = 32'(clamp32(nx));
			r.y = 32'(clamp32(ny));
			r.z = 32'(clamp32(nz));
			r.last = (i + 1 == batch_len);
			transformed_points = {transformed_points, r};
		end
		batch_len = 0;
		acc_x = 0; acc_y = 0; acc_z = 0;
	endtask

	// configuration shadow
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_reg <= 4'd10; given_centre <= 1'b0;
			centre_x <= '0; centre_y <= '0; centre_z <= '0;
			cos_sin <= 64'd1073741824; scale_pair <= 64'h0100_0000_0100_0000;
			step_reg <= 31'd65536;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OP:    op_reg <= cfg_data[3:0];
				REG_USEC:  given_centre <= cfg_data[0];
				REG_CX:    centre_x <= cfg_data[31:0];
				REG_CY:    centre_y <= cfg_data[31:0];
				REG_CZ:    centre_z <= cfg_data[31:0];
				REG_ROT:   cos_sin <= cfg_data;
				REG_SCALE: scale_pair <= cfg_data;
				REG_STEP:  step_reg <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// input transfers feed the predictor
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			if (batch_len < 64) begin
				batch_x[batch_len] = s_axis_tdata[31:0];
				batch_y[batch_len] = s_axis_tdata[63:32];
				batch_z[batch_len] = s_axis_tdata[95:64];
				acc_x += longint'(signed'(s_axis_tdata[31:0]));
				acc_y += longint'(signed'(s_axis_tdata[63:32]));
				acc_z += longint'(signed'(s_axis_tdata[95:64]));
				batch_len++;
			end
			if (s_axis_tlast) transform_batch();
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_points.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
					point_t p;
					p = pending_points.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {p.z, p.y, p.x};
					s_axis_tlast <= p.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (transformed_points.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected transfer %h last %b", m_axis_tdata,
						m_axis_tlast);
				end else begin
					point_t e;
					e = transformed_points.pop_front();
					if (m_axis_tdata !== {e.z, e.y, e.x} || m_axis_tlast !== e.last) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp x %h y %h z %h last %b, got x %h y %h z %h last %b",
								e.x, e.y, e.z, e.last, m_axis_tdata[31:0], m_axis_tdata[63:32],
								m_axis_tdata[95:64], m_axis_tlast);
					end
				end
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
				(cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= 20000) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 20'sh80000);
			default: return $urandom();
		endcase
	endfunction

	task automatic add_batch(int n);
		point_t p;
		for (int i = 0; i < n; i++) begin
			p.x = coord(); p.y = coord(); p.z = coord();
			p.last = (i == n - 1);
			pending_points = {pending_points, p};
		end
	endtask

	task automatic wait_drained();
		while (pending_points.size() > 0 || s_axis_tvalid || transformed_points.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	initial begin
		point_t p;
		int fed;
		send_idle = 38; recv_idle = 85;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// default registers, extreme points
		p = '{z: 32'h8000_0000, y: 32'h7FFF_FFFF, x: 32'h8000_0000, last: 1'b0};
		pending_points = {pending_points, p};
		p = '{z: 32'h7FFF_FFFF, y: 32'h8000_0000, x: 32'h7FFF_FFFF, last: 1'b1};
		pending_points = {pending_points, p};
		wait_drained();
		for (int ph = 0; ph < 14; ph++) begin
			if (ph == 5) begin send_idle = 85; recv_idle = 38; end
			if (ph == 10) begin send_idle = 0; recv_idle = 0; end
			write_reg(REG_OP, (ph <= 10) ? 64'(ph) : 64'($urandom_range(0, 15)));
			write_reg(REG_USEC, (ph < 3) ? 64'(ph[0]) : 64'($urandom_range(0, 1)));
			write_reg(REG_CX, (ph % 4 == 0) ? 64'h8000_0000 :
				(ph % 4 == 1) ? 64'h7FFF_FFFF : 64'(coord()));
			write_reg(REG_CY, (ph % 4 == 1) ? 64'h8000_0000 : 64'(coord()));
			write_reg(REG_CZ, (ph % 4 == 2) ? 64'h7FFF_FFFF : 64'(coord()));
			case (ph % 4)
				0: write_reg(REG_ROT, 64'h8000_0000_8000_0000);
				1: write_reg(REG_ROT, 64'h7FFF_FFFF_7FFF_FFFF);
				default: write_reg(REG_ROT, {$urandom(), $urandom()});
			endcase
			case (ph % 5)
				0: write_reg(REG_SCALE, 64'hFFFF_FFFF_FFFF_FFFF);
				1: write_reg(REG_SCALE, 64'h0);
				default: write_reg(REG_SCALE, {$urandom(), $urandom()});
			endcase
			case (ph % 3)
				0: write_reg(REG_STEP, 64'h7FFF_FFFF);
				1: write_reg(REG_STEP, 64'h0);
				default: write_reg(REG_STEP, 64'($urandom_range(0, 32'h7FFF_FFFF)));
			endcase
			// one extreme pair per setting
			p = '{z: 32'h7FFF_FFFF, y: 32'h8000_0000, x: 32'h7FFF_FFFF, last: 1'b0};
			pending_points = {pending_points, p};
			p = '{z: 32'h8000_0000, y: 32'h7FFF_FFFF, x: 32'h8000_0000, last: 1'b1};
			pending_points = {pending_points, p};
			fed = 0;
			if (ph == 4) begin add_batch(64); fed = 64; end
			if (ph == 9) begin add_batch(67); fed = 67; end
			while (fed < 12) begin
				int n;
				n = $urandom_range(1, 6);
				add_batch(n);
				fed += n;
			end
			wait_drained();
		end
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

module point_transform_about_center_top_stub_guard;
endmodule
